@@ rtl/rit_pkg.sv @@
// Shared types, constants and helper functions of the radix integer-to-text converter.
package rit_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 41;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + MAX_DIGITS);

  typedef logic [3:0] digit_t;
  typedef logic [4:0] radix_t;
  typedef logic [7:0] char_t;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_RADIX      = 2'd0;
  localparam cfg_index_t CFG_CHARS_LOW  = 2'd1;
  localparam cfg_index_t CFG_CHARS_HIGH = 2'd2;

  localparam radix_t      RADIX_MIN        = 5'd3;
  localparam radix_t      RADIX_MAX        = 5'd16;
  localparam radix_t      RADIX_RESET      = 5'd16;
  localparam logic [63:0] CHARS_LOW_RESET  = 64'd3978425819141910832;
  localparam logic [63:0] CHARS_HIGH_RESET = 64'd7378413942531504440;

  localparam char_t PREFIX_ZERO = 8'h30;
  localparam char_t PREFIX_X    = 8'h78;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  function automatic radix_t clamp_radix(input radix_t r);
    radix_t res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic char_t map_digit(input digit_t d, input logic [63:0] lo,
                                      input logic [63:0] hi);
    logic [127:0] chars;
    chars = {hi, lo};
    return chars[{d, 3'b000} +: 8];
  endfunction

endpackage

@@ rtl/rit_cell.sv @@
// One digit cell: doubles its digit and adds the incoming bit modulo the radix, or clears or shifts.
module rit_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rit_pkg::cell_ctl_t ctl,
  input  rit_pkg::radix_t   radix,
  input  logic              carry_in,
  input  logic              valid_in,
  input  rit_pkg::digit_t   shift_in,
  output rit_pkg::digit_t   digit,
  output logic              carry_out,
  output logic              valid_out
);
  import rit_pkg::*;

  digit_t digit_r, digit_nxt;
  logic   carry_r, carry_nxt;
  logic   valid_r;
  logic [4:0] twice;
  logic [4:0] reduced;
  logic       over;

  always_comb begin
    twice   = {digit_r, carry_in};
    over    = (twice >= radix);
    reduced = twice - radix;
    digit_nxt = digit_r;
    carry_nxt = 1'b0;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.shift) begin
      digit_nxt = shift_in;
    end else if (valid_in) begin
      digit_nxt = over ? reduced[3:0] : twice[3:0];
      carry_nxt = over;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
    if (!rst_n) begin
      carry_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
      valid_r <= valid_in & ~ctl.clear & ~ctl.shift;
    end
  end

  assign digit     = digit_r;
  assign carry_out = carry_r;
  assign valid_out = valid_r;
endmodule

@@ rtl/rit_chain.sv @@
// Row of digit cells; bits enter at the least significant cell, digits leave at the top.
module rit_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  rit_pkg::cell_ctl_t ctl,
  input  rit_pkg::radix_t    radix,
  input  logic               bit_in,
  input  logic               bit_valid,
  output rit_pkg::digit_t    top_digit,
  output logic               overflow
);
  import rit_pkg::*;

  digit_t digit [MAX_DIGITS];
  logic   carry [MAX_DIGITS];
  logic   valid [MAX_DIGITS];

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    if (k == 0) begin : g_first
      rit_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .radix     (radix),
        .carry_in  (bit_in),
        .valid_in  (bit_valid),
        .shift_in  ('0),
        .digit     (digit[k]),
        .carry_out (carry[k]),
        .valid_out (valid[k])
      );
    end else begin : g_next
      rit_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .radix     (radix),
        .carry_in  (carry[k-1]),
        .valid_in  (valid[k-1]),
        .shift_in  (digit[k-1]),
        .digit     (digit[k]),
        .carry_out (carry[k]),
        .valid_out (valid[k])
      );
    end
  end

  assign top_digit = digit[MAX_DIGITS-1];
  assign overflow  = carry[MAX_DIGITS-1] & valid[MAX_DIGITS-1];
endmodule

@@ rtl/radix_integer_to_text.sv @@
// Top level of the radix integer-to-text converter: control, registers and output stage.
//
// Input channel in_valid/in_ready takes one beat per value (in_value, in_with_prefix).
// Output channel out_valid/out_ready gives one beat per character (out_char_out,
// out_last); out_last marks the final digit of a value.
// Configuration channel cfg_valid/cfg_ready writes radix (index 0) and the two
// character tables (indexes 1 and 2); it is always ready. It must be written only while
// idle; the block itself does not enforce this. Conversion shifts the value, most
// significant bit first, into a row of 41 digit cells, and each bit ripples up the row
// through the registered carries of the cells. The optional prefix then goes out, and
// the digits leave the top cell one per cycle while the receiver does not stall,
// leading zeros being dropped. A stall holds the output register and, while digits are
// emitted, the cell row; skipped leading zeros also wait.
// The next value is accepted while the final character still waits to be taken.
// Reset restores radix 16 and the tables "01234567" and "89abcdef", and idles the block.
module radix_integer_to_text (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [63:0]                    in_value,
  input  logic                           in_with_prefix,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_char_out,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  rit_pkg::cfg_index_t            cfg_index,
  input  logic [63:0]                    cfg_data
);
  import rit_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_PRE0 = 5'b00100,
    S_PRE1 = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic prefix_r, prefix_nxt;
  logic started_r, started_nxt;
  radix_t radix_r;
  logic [63:0] chars_lo_r, chars_hi_r;
  logic out_valid_r, out_valid_nxt;
  char_t out_char_r, out_char_nxt;
  logic out_last_r, out_last_nxt;

  logic out_free, accept;
  cell_ctl_t ctl;
  digit_t top_digit;
  logic bit_valid;
  logic overflow;

  assign out_free  = ~out_valid_r | out_ready;
  assign accept    = in_valid & in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign bit_valid = (state_r == S_CONV) && (cnt_r < CNT_W'(VALUE_WIDTH));

  always_comb begin
    ctl.clear = accept;
    ctl.shift = (state_r == S_EMIT) & out_free;
  end

  rit_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .radix     (clamp_radix(radix_r)),
    .bit_in    (val_r[VALUE_WIDTH-1]),
    .bit_valid (bit_valid),
    .top_digit (top_digit),
    .overflow  (overflow)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    prefix_nxt    = prefix_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt     = in_value[VALUE_WIDTH-1:0];
          prefix_nxt  = in_with_prefix;
          started_nxt = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        val_nxt = {val_r[VALUE_WIDTH-2:0], 1'b0};
        if (cnt_r == CNT_W'(VALUE_WIDTH + MAX_DIGITS - 2)) begin
          cnt_nxt   = '0;
          state_nxt = prefix_r ? S_PRE0 : S_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_PRE0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = PREFIX_ZERO;
          out_last_nxt  = 1'b0;
          state_nxt     = S_PRE1;
        end
      end
      S_PRE1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = PREFIX_X;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = map_digit(top_digit, chars_lo_r, chars_hi_r);
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end else if (started_r || (top_digit != '0)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = map_digit(top_digit, chars_lo_r, chars_hi_r);
            out_last_nxt  = 1'b0;
            started_nxt   = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (overflow) begin
      started_nxt = started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      prefix_r    <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prefix_r    <= prefix_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RESET;
      chars_lo_r <= CHARS_LOW_RESET;
      chars_hi_r <= CHARS_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX:      radix_r    <= cfg_data[4:0];
        CFG_CHARS_LOW:  chars_lo_r <= cfg_data;
        CFG_CHARS_HIGH: chars_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;
endmodule

@@ tb/sv/radix_text_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts the character stream of the radix converter and compares each beat.
module radix_text_checker
  import rit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_value,
  input  logic        in_with_prefix,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_char_out,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [63:0] cfg_data,
  output int          outstanding,
  output int          mismatches,
  output int          values_seen,
  output int          chars_seen
);

  typedef struct packed {
    char_t ch;
    logic  last;
  } text_beat_t;

  text_beat_t  expected_text[$];
  radix_t      radix_reg;
  logic [63:0] chars_lo;
  logic [63:0] chars_hi;

  function automatic longint unsigned effective_base(input radix_t r);
    if (r < RADIX_MIN) return 64'(RADIX_MIN);
    if (r > RADIX_MAX) return 64'(RADIX_MAX);
    return 64'(r);
  endfunction

  function automatic char_t digit_char(input logic [3:0] d);
    if (d[3]) return chars_hi[8 * int'(d[2:0]) +: 8];
    return chars_lo[8 * int'(d[2:0]) +: 8];
  endfunction

  task automatic predict_text(input logic [63:0] value, input logic with_prefix);
    logic [3:0]        digits[$];
    longint unsigned   base;
    longint unsigned   rest;
    base = effective_base(radix_reg);
    rest = value;
    do begin
      digits.push_back(4'(rest % base));
      rest = rest / base;
    end while (rest != 0 && digits.size() < MAX_DIGITS);
    if (with_prefix) begin
      expected_text.push_back('{ch: PREFIX_ZERO, last: 1'b0});
      expected_text.push_back('{ch: PREFIX_X, last: 1'b0});
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      expected_text.push_back('{ch: digit_char(digits[i]), last: (i == 0)});
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst_n) begin
      radix_reg = RADIX_RESET;
      chars_lo  = CHARS_LOW_RESET;
      chars_hi  = CHARS_HIGH_RESET;
      expected_text.delete();
    end else begin
      if (out_valid && out_ready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("character beat 0x%02h with nothing expected",
                                    out_char_out));
        end else begin
          want = expected_text.pop_front();
          if (out_char_out !== want.ch)
            report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                      out_char_out, want.ch));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, expected %b on char 0x%02h",
                                      out_last, want.last, want.ch));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIX:      radix_reg = cfg_data[4:0];
          CFG_CHARS_LOW:  chars_lo  = cfg_data;
          CFG_CHARS_HIGH: chars_hi  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        values_seen++;
        predict_text(in_value, in_with_prefix);
      end
    end
    outstanding <= expected_text.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, stimulus for the radix converter and the final verdict.
module tb;
  import rit_pkg::*;

  localparam logic [63:0] CHARS_HIGH_UPPER = 64'h4645_4443_4241_3938;
  localparam logic [63:0] ALL_ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_value;
  logic        in_with_prefix;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char_out;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [63:0] cfg_data;

  int     outstanding;
  int     mismatches;
  int     values_seen;
  int     chars_seen;
  int     sent_count;
  int     settings_count;
  int     beat_count;
  radix_t cur_radix;

  radix_integer_to_text uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_with_prefix (in_with_prefix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  radix_text_checker text_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_with_prefix (in_with_prefix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .mismatches     (mismatches),
    .values_seen    (values_seen),
    .chars_seen     (chars_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Run stopped by the time limit.");
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int unsigned draw_gap(input int n);
    if (n % 48 < 12) return 0;
    return $urandom_range(0, 6);
  endfunction

  // The receiver may stall for a random gap before each beat; some runs of beats get no gap.
  initial begin
    int unsigned gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(beat_count + 20);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beat_count++;
    end
  end

  task automatic send_value(input logic [63:0] v, input logic with_prefix);
    int unsigned gap;
    gap = draw_gap(sent_count);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= v;
    in_with_prefix <= with_prefix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Upper bits of the radix write are random; only the low five bits count.
  task automatic configure(input radix_t r, input logic [63:0] lo, input logic [63:0] hi);
    drain();
    write_reg(CFG_RADIX, {32'($urandom), 27'($urandom), r});
    write_reg(CFG_CHARS_LOW, lo);
    write_reg(CFG_CHARS_HIGH, hi);
    cfg_valid <= 1'b0;
    cur_radix = r;
    settings_count++;
  endtask

  function automatic logic [63:0] random_value(input radix_t r);
    logic [63:0] p;
    int unsigned k;
    int unsigned base;
    base = 32'((r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r);
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 400));
      2: return {$urandom, $urandom} >> $urandom_range(1, 63);
      3: begin
        p = 64'd1;
        k = $urandom_range(1, 40);
        repeat (k) p = p * 64'(base);
        return p - 64'($urandom_range(0, 1));
      end
      4: return ALL_ONES - 64'($urandom_range(0, 400));
      default: return {$urandom, $urandom} & {2{$urandom}};
    endcase
  endfunction

  initial begin
    radix_t      r;
    logic [63:0] lo;
    logic [63:0] hi;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_with_prefix <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_RADIX;
    cfg_data       <= '0;
    cur_radix      = RADIX_RESET;
    settings_count = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: hexadecimal with lowercase letters.
    send_value(64'd0, 1'b0);
    send_value(64'd0, 1'b1);
    send_value(ALL_ONES, 1'b1);
    send_value(64'd1, 1'b0);
    send_value(64'h8000_0000_0000_0000, 1'b0);
    send_value(64'h0123_4567_89AB_CDEF, 1'b1);

    // Smallest radix: the all-ones value gives the longest run.
    configure(5'd3, CHARS_LOW_RESET, CHARS_HIGH_RESET);
    send_value(ALL_ONES, 1'b1);
    send_value(64'd0, 1'b0);
    send_value(64'd2, 1'b0);
    send_value(64'd3, 1'b1);
    send_value(64'd12157665459056928801, 1'b0);

    // Out-of-range radix values saturate at three and sixteen.
    configure(5'd0, CHARS_LOW_RESET, CHARS_HIGH_UPPER);
    send_value(64'd9, 1'b1);
    send_value(ALL_ONES, 1'b0);
    configure(5'd2, ALL_ONES, 64'd0);
    send_value(64'd8, 1'b0);
    configure(5'd31, 64'd0, ALL_ONES);
    send_value(ALL_ONES, 1'b0);
    send_value(64'h00FF_00FF_00FF_00FF, 1'b1);
    configure(5'd17, {$urandom, $urandom}, {$urandom, $urandom});
    send_value(64'd255, 1'b0);
    send_value({$urandom, $urandom}, 1'b1);
    configure(5'd10, CHARS_LOW_RESET, CHARS_HIGH_UPPER);
    send_value(ALL_ONES, 1'b1);
    send_value(64'd10, 1'b0);
    send_value(64'd9, 1'b0);

    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0) r = 5'd3;
      else if (phase == 1) r = 5'd16;
      else if ($urandom_range(0, 3) == 0) r = radix_t'($urandom_range(0, 31));
      else r = radix_t'($urandom_range(3, 16));
      lo = ($urandom_range(0, 1) == 0) ? CHARS_LOW_RESET : {$urandom, $urandom};
      case ($urandom_range(0, 2))
        0: hi = CHARS_HIGH_RESET;
        1: hi = CHARS_HIGH_UPPER;
        default: hi = {$urandom, $urandom};
      endcase
      configure(r, lo, hi);
      for (int i = 0; i < 21; i++) begin
        if (phase == 2 && i == 10) drain();
        send_value(random_value(cur_radix), 1'($urandom_range(0, 1)));
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Summary: %0d values under %0d register settings, radix written from 0 to 31.",
             values_seen, settings_count);
    $display("Summary: %0d characters compared, %0d mismatches, %0d still expected.",
             chars_seen, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ radix_integer_to_text.f @@
rtl/rit_pkg.sv
rtl/rit_cell.sv
rtl/rit_chain.sv
rtl/radix_integer_to_text.sv
tb/sv/radix_text_checker.sv
tb/sv/tb.sv
